// ----- rtl/sgr_pkg.sv -----
// ---------------------------------------------------------------------------
// sgr_pkg
// Shared types and codes for the SGR attribute tracker: the attribute word,
// the extended color phase codes and the fixed code values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sgr_pkg;

  localparam int ParamWidth = 16;
  localparam int ColorWidth = 8;
  localparam int PhaseWidth = 3;

  // Extended color phase codes.
  localparam logic [PhaseWidth-1:0] PH_IDLE   = 3'd0;
  localparam logic [PhaseWidth-1:0] PH_FG_SEL = 3'd1;
  localparam logic [PhaseWidth-1:0] PH_BG_SEL = 3'd2;
  localparam logic [PhaseWidth-1:0] PH_FG_IDX = 3'd3;
  localparam logic [PhaseWidth-1:0] PH_BG_IDX = 3'd4;

  // SGR code values.
  localparam logic [ParamWidth-1:0] CODE_RESET     = 16'd0;
  localparam logic [ParamWidth-1:0] CODE_BOLD      = 16'd1;
  localparam logic [ParamWidth-1:0] CODE_UNDER     = 16'd4;
  localparam logic [ParamWidth-1:0] CODE_INV       = 16'd7;
  localparam logic [ParamWidth-1:0] CODE_BOLD_OFF  = 16'd22;
  localparam logic [ParamWidth-1:0] CODE_UNDER_OFF = 16'd24;
  localparam logic [ParamWidth-1:0] CODE_INV_OFF   = 16'd27;
  localparam logic [ParamWidth-1:0] CODE_FG_EXT    = 16'd38;
  localparam logic [ParamWidth-1:0] CODE_FG_DFLT   = 16'd39;
  localparam logic [ParamWidth-1:0] CODE_BG_EXT    = 16'd48;
  localparam logic [ParamWidth-1:0] CODE_BG_DFLT   = 16'd49;
  localparam logic [ParamWidth-1:0] CODE_EXT_256   = 16'd5;

  // Range bases, applied to the low byte of the parameter.
  localparam logic [ColorWidth-1:0] FG_BASE        = 8'd30;
  localparam logic [ColorWidth-1:0] BG_BASE        = 8'd40;
  localparam logic [ColorWidth-1:0] FG_BRIGHT_BASE = 8'd82;  // 90 minus 8
  localparam logic [ColorWidth-1:0] BG_BRIGHT_BASE = 8'd92;  // 100 minus 8

  localparam logic [ColorWidth-1:0] FG_DEFAULT = 8'd7;
  localparam logic [ColorWidth-1:0] BG_DEFAULT = 8'd0;
  localparam logic [ColorWidth-1:0] INDEX_MAX  = 8'd255;

  typedef struct packed {
    logic                  inverse;
    logic                  underline;
    logic                  bold;
    logic [ColorWidth-1:0] bg;
    logic [ColorWidth-1:0] fg;
  } attr_t;

  typedef struct packed {
    logic [PhaseWidth-1:0] phase;
    attr_t                 attr;
  } track_state_t;

endpackage

`default_nettype wire

// ----- rtl/sgr_decode.sv -----
// ---------------------------------------------------------------------------
// sgr_decode
// Next-state logic for one SGR parameter: style codes, base and bright
// colors, defaults, reset and the 38;5;n / 48;5;n extended forms.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sgr_decode (
  input  wire sgr_pkg::track_state_t           cur,
  input  wire logic [sgr_pkg::ParamWidth-1:0]  param_value,
  input  wire logic                            last_param,
  input  wire logic                            no_params,
  output sgr_pkg::track_state_t                nxt
);

  sgr_pkg::attr_t                    reset_attr;
  sgr_pkg::attr_t                    code_attr;
  logic [sgr_pkg::PhaseWidth-1:0]    code_phase;
  logic [sgr_pkg::ColorWidth-1:0]    ext_index;
  logic [sgr_pkg::ColorWidth-1:0]    low_byte;

  assign low_byte  = param_value[sgr_pkg::ColorWidth-1:0];
  assign ext_index = (param_value > 16'd255) ? sgr_pkg::INDEX_MAX : low_byte;

  always_comb begin
    reset_attr           = '0;
    reset_attr.fg        = sgr_pkg::FG_DEFAULT;
    reset_attr.bg        = sgr_pkg::BG_DEFAULT;
  end

  // Ordinary code decode; unknown codes leave the attributes as they were.
  always_comb begin
    code_attr  = cur.attr;
    code_phase = sgr_pkg::PH_IDLE;
    case (param_value) inside
      sgr_pkg::CODE_RESET:     code_attr = reset_attr;
      sgr_pkg::CODE_BOLD:      code_attr.bold = 1'b1;
      sgr_pkg::CODE_UNDER:     code_attr.underline = 1'b1;
      sgr_pkg::CODE_INV:       code_attr.inverse = 1'b1;
      sgr_pkg::CODE_BOLD_OFF:  code_attr.bold = 1'b0;
      sgr_pkg::CODE_UNDER_OFF: code_attr.underline = 1'b0;
      sgr_pkg::CODE_INV_OFF:   code_attr.inverse = 1'b0;
      sgr_pkg::CODE_FG_DFLT:   code_attr.fg = sgr_pkg::FG_DEFAULT;
      sgr_pkg::CODE_BG_DFLT:   code_attr.bg = sgr_pkg::BG_DEFAULT;
      [16'd30:16'd37]:         code_attr.fg = low_byte - sgr_pkg::FG_BASE;
      [16'd40:16'd47]:         code_attr.bg = low_byte - sgr_pkg::BG_BASE;
      [16'd90:16'd97]:         code_attr.fg = low_byte - sgr_pkg::FG_BRIGHT_BASE;
      [16'd100:16'd107]:       code_attr.bg = low_byte - sgr_pkg::BG_BRIGHT_BASE;
      sgr_pkg::CODE_FG_EXT:    code_phase = sgr_pkg::PH_FG_SEL;
      sgr_pkg::CODE_BG_EXT:    code_phase = sgr_pkg::PH_BG_SEL;
      default:                 code_attr = cur.attr;
    endcase
  end

  always_comb begin
    nxt.attr  = cur.attr;
    nxt.phase = sgr_pkg::PH_IDLE;
    if (no_params) begin
      nxt.attr = reset_attr;
    end else begin
      case (cur.phase)
        sgr_pkg::PH_FG_IDX: nxt.attr.fg = ext_index;
        sgr_pkg::PH_BG_IDX: nxt.attr.bg = ext_index;
        sgr_pkg::PH_FG_SEL, sgr_pkg::PH_BG_SEL: begin
          if (param_value == sgr_pkg::CODE_EXT_256) begin
            // A trailing 5 is dropped; otherwise wait for the color index.
            nxt.phase = (cur.phase == sgr_pkg::PH_FG_SEL) ?
                        sgr_pkg::PH_FG_IDX : sgr_pkg::PH_BG_IDX;
          end else begin
            nxt.attr  = code_attr;
            nxt.phase = code_phase;
          end
        end
        default: begin
          nxt.attr  = code_attr;
          nxt.phase = code_phase;
        end
      endcase
      if (last_param) begin
        nxt.phase = sgr_pkg::PH_IDLE;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sgr_attribute_tracker_top.sv -----
// ---------------------------------------------------------------------------
// sgr_attribute_tracker_top
// Tracks text attributes across ANSI SGR sequences, one parameter per word,
// and returns the attributes as they stand after every parameter.
// ---------------------------------------------------------------------------
//
//   Channel   Dir   tdata                               tlast       tuser
//   s_axis    in    [15:0] param_value                  last_param  no_params
//   m_axis    out   [7:0] fg, [15:8] bg, [16] bold,     -           -
//                   [17] underline, [18] inverse
//
// One word is accepted per cycle while s_axis_tready is high; its result is
// registered in the result register, or in the skid register while m_axis
// stalls. The attribute update is a single decode stage between the state
// registers and the result register. A two-entry output (result register
// plus skid register) lets s_axis take one more word while m_axis stalls;
// tready drops only while the skid register is full.
// Reset restores foreground 7, background 0, no styles, and drops results.
//
`timescale 1ns / 1ps
`default_nettype none

module sgr_attribute_tracker_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] param_value
  input  wire logic        s_axis_tlast,
  input  wire logic        s_axis_tuser,   // [0] no_params
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [23:0] m_axis_tdata    // fg, bg, bold, underline, inverse, pad
);

  sgr_pkg::track_state_t state;
  sgr_pkg::track_state_t state_next;
  sgr_pkg::attr_t        out_attr;
  sgr_pkg::attr_t        skid_attr;
  logic                  out_valid;
  logic                  skid_valid;
  logic                  accept;
  logic                  pop;

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = out_valid && m_axis_tready;

  sgr_decode u_decode (
    .cur         (state),
    .param_value (s_axis_tdata),
    .last_param  (s_axis_tlast),
    .no_params   (s_axis_tuser),
    .nxt         (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      // Phase, then inverse, underline, bold, background and foreground.
      state <= {sgr_pkg::PH_IDLE, 3'b000, sgr_pkg::BG_DEFAULT, sgr_pkg::FG_DEFAULT};
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_attr   <= skid_attr;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
        if (accept) begin
          out_attr <= state_next.attr;
        end
      end
    end else if (accept) begin
      // Result register is stalled; park this word's result.
      skid_attr  <= state_next.attr;
      skid_valid <= 1'b1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_attr.inverse, out_attr.underline, out_attr.bold,
                          out_attr.bg, out_attr.fg};

endmodule

`default_nettype wire
